### sv/vgm_to_compact_music_bytecode_top_assert.svh
// Assertion macros shared by the checker of the bytecode emitter.
`ifndef VGM_TO_COMPACT_MUSIC_BYTECODE_TOP_ASSERT_SVH
`define VGM_TO_COMPACT_MUSIC_BYTECODE_TOP_ASSERT_SVH

// Implication checked in the same cycle, switched off during reset.
`define VGM_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Implication checked in the next cycle, switched off during reset.
`define VGM_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

// Implication checked in the next cycle, active during reset as well.
`define VGM_ASSERT_ALWAYS_NEXT(label, clk, ante, cons, msg) \
   label: assert property (@(posedge clk) (ante) |=> (cons)) \
      else $error(msg);

`endif

### sv/vgm_pkg.sv
`default_nettype none
package vgm_pkg;

   // Command kinds carried by a request.
   typedef enum logic [2:0] {
      KIND_AY         = 3'd0,
      KIND_SCC        = 3'd1,
      KIND_WAIT_N     = 3'd2,
      KIND_WAIT_735   = 3'd3,
      KIND_WAIT_882   = 3'd4,
      KIND_WAIT_SHORT = 3'd5,
      KIND_END        = 3'd6,
      KIND_IGNORED    = 3'd7
   } kind_type;

   // Sequencer states.
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_FLUSH,
      ST_ACT,
      ST_DIV_START,
      ST_DIV,
      ST_FW
   } state_type;

   // Which part of a command is being worked on.
   typedef enum logic [1:0] {
      PH_ACT,
      PH_FW50,
      PH_FW60
   } phase_type;

   // Result of the frame divider.
   typedef struct packed {
      logic        done;
      logic [7:0]  quot;
      logic [16:0] rem;
   } div_res_type;

   // Configuration register indexes.
   localparam logic [7:0] CSR_FRAME_MODE    = 8'd0;
   localparam logic [7:0] CSR_LOOP_ENABLE   = 8'd1;
   localparam logic [7:0] CSR_LOOP_POSITION = 8'd2;
   localparam logic [7:0] CSR_OUTPUT_BASE   = 8'd3;

   // Bytecode opcodes.
   localparam logic [7:0] OP_BLOCK      = 8'hF5;
   localparam logic [7:0] OP_SINGLE     = 8'hF3;
   localparam logic [7:0] OP_LOOP       = 8'hFE;
   localparam logic [7:0] OP_END        = 8'hFF;
   localparam logic [7:0] OP_FW50       = 8'hD0;
   localparam logic [7:0] OP_FW60       = 8'hE0;
   localparam logic [7:0] OP_PACK_MASK  = 8'h0F;
   localparam logic [7:0] OP_SCC_FREQ   = 8'hF0;
   localparam logic [7:0] OP_SCC_NIBBLE = 8'hF1;
   localparam logic [7:0] OP_AY_R1      = 8'h10;
   localparam logic [7:0] OP_AY_R3      = 8'h20;
   localparam logic [7:0] OP_AY_R5      = 8'h30;
   localparam logic [7:0] OP_AY_R6      = 8'h40;
   localparam logic [7:0] OP_AY_R8      = 8'h60;
   localparam logic [7:0] OP_AY_R9      = 8'h80;
   localparam logic [7:0] OP_AY_R10     = 8'hA0;
   localparam logic [7:0] OP_AY_R13     = 8'hC0;
   localparam logic [7:0] OP_AY_HI      = 8'h10;

   // AY register numbers.
   localparam logic [7:0] AY_R0  = 8'd0;
   localparam logic [7:0] AY_R1  = 8'd1;
   localparam logic [7:0] AY_R2  = 8'd2;
   localparam logic [7:0] AY_R3  = 8'd3;
   localparam logic [7:0] AY_R4  = 8'd4;
   localparam logic [7:0] AY_R5  = 8'd5;
   localparam logic [7:0] AY_R6  = 8'd6;
   localparam logic [7:0] AY_R7  = 8'd7;
   localparam logic [7:0] AY_R8  = 8'd8;
   localparam logic [7:0] AY_R9  = 8'd9;
   localparam logic [7:0] AY_R10 = 8'd10;
   localparam logic [7:0] AY_R11 = 8'd11;
   localparam logic [7:0] AY_R12 = 8'd12;
   localparam logic [7:0] AY_R13 = 8'd13;

   // SCC register boundaries.
   localparam logic [7:0] SCC_REG_LOW     = 8'h80;
   localparam logic [7:0] SCC_REG_FREQ_HI = 8'h88;
   localparam logic [7:0] SCC_REG_NIB_LO  = 8'h81;
   localparam logic [7:0] SCC_REG_NIB_HI  = 8'h8E;
   localparam logic [7:0] SCC_REG_MODE    = 8'h8F;

   // Wait constants and frame periods in samples.
   localparam logic [16:0] WAIT_735  = 17'd735;
   localparam logic [16:0] WAIT_882  = 17'd882;
   localparam logic [16:0] FRAMES_50 = 17'd882;
   localparam logic [16:0] FRAMES_60 = 17'd735;

   // Base address of each SCC port selector; unknown selectors map to zero.
   function automatic logic [7:0] scc_base(input logic [7:0] port);
      logic [7:0] base;
      case (port)
         8'd1:    base = 8'h80;
         8'd2:    base = 8'h8A;
         8'd3:    base = 8'h8F;
         8'd4:    base = 8'hA0;
         8'd5:    base = 8'hE0;
         default: base = 8'h00;
      endcase
      return base;
   endfunction

endpackage
`default_nettype wire

### sv/vgm_chan_if.sv
`default_nettype none
// Request channel: one decoded command.
interface vgm_req_if;
   logic        valid;
   logic        ready;
   logic [2:0]  kind;
   logic [7:0]  reg_or_port;
   logic [7:0]  reg_offset;
   logic [7:0]  data_value;
   logic [15:0] wait_samples;
   modport source (output valid, kind, reg_or_port, reg_offset, data_value, wait_samples,
                   input ready);
   modport sink (input valid, kind, reg_or_port, reg_offset, data_value, wait_samples,
                 output ready);
endinterface

// Result channel: one bytecode byte.
interface vgm_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] out_byte;
   logic       last;
   modport source (output valid, out_byte, last, input ready);
   modport sink (input valid, out_byte, last, output ready);
endinterface

// Configuration write channel.
interface vgm_csr_if;
   logic        valid;
   logic        ready;
   logic [7:0]  index;
   logic [31:0] data;
   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

### sv/vgm_to_compact_music_bytecode_top.sv
`default_nettype none
// Converts decoded VGM commands into compact music bytecode, one byte per response.
// A command is taken only when the previous one has produced all of its bytes.
// Emitted bytes go out one per cycle while the response side is ready. A run flush
// sends three bytes for a single value and the run length plus three for a block.
// Each frame wait works out its frame count by reciprocal multiplication, then
// emits its bytes. Run values live in a MAX_RUN-entry memory read one value per
// cycle during a flush while the response side is ready. The last byte caused by a
// command is marked with last. Writing output_base also reloads the output address.
module vgm_to_compact_music_bytecode_top #(
   parameter int MAX_RUN = 32
) (
   input wire logic   clock,
   input wire logic   reset,
   vgm_req_if.sink    req_chan,
   vgm_rsp_if.source  rsp_chan,
   vgm_csr_if.sink    csr_chan
);
   import vgm_pkg::*;

   localparam int RUN_AW = $clog2(MAX_RUN);
   localparam logic [7:0] RUN_MAX = 8'(MAX_RUN);

   // Configuration.
   logic [1:0]  frame_mode_ff, frame_mode_in;
   logic        loop_enable_ff, loop_enable_in;
   logic [31:0] loop_pos_ff, loop_pos_in;

   // Song state.
   logic [16:0] c50_ff, c50_in, c60_ff, c60_in;
   logic [7:0]  run_len_ff, run_len_in;
   logic [7:0]  run_first_ff, run_first_in;
   logic [7:0]  run_last_ff, run_last_in;
   logic [15:0] out_addr_ff, out_addr_in;
   logic [15:0] mark_ff, mark_in;
   logic [15:0] loop_addr_ff, loop_addr_in;
   logic        loop_found_ff, loop_found_in;
   logic [31:0] stream_pos_ff, stream_pos_in;

   // Sequencer.
   state_type   state_ff, state_in;
   phase_type   phase_ff, phase_in;
   logic [8:0]  idx_ff, idx_in;
   logic [1:0]  act_cnt_ff, act_cnt_in;
   logic [7:0]  act_b0_ff, act_b0_in, act_b1_ff, act_b1_in, act_b2_ff, act_b2_in;
   logic        append_ff, append_in;
   logic [7:0]  app_reg_ff, app_reg_in, app_val_ff, app_val_in;
   logic        f50_ff, f50_in, f60_ff, f60_in;
   logic [3:0]  packs_ff, packs_in;
   logic [7:0]  fin_ff, fin_in;

   // Response register.
   logic        rsp_valid_ff, rsp_valid_in;
   logic [7:0]  rsp_byte_ff, rsp_byte_in;
   logic        rsp_last_ff, rsp_last_in;

   // Decode and helpers.
   kind_type    kind;
   logic [7:0]  rp, dv;
   logic [16:0] samp, c50_sum, c60_sum;
   logic [32:0] sp_sum;
   logic [31:0] sp_new;
   logic [1:0]  adv;
   logic [15:0] mark_new;
   logic [7:0]  scc_reg, lo8, hi8;
   logic        d_flush, d_append, d_f50, d_f60;
   logic [1:0]  d_cnt;
   logic [7:0]  d_b0, d_b1, d_b2;
   logic        can_emit, emit, emit_last;
   logic [7:0]  emit_byte;
   logic [8:0]  fl_total, fl_hdr, fl_k;
   logic        later;
   logic        wr_en;
   logic [RUN_AW-1:0] rd_addr;
   logic [7:0]  rd_data;
   logic        div_start;
   logic [16:0] div_dividend, div_divisor;
   div_res_type div_res;
   logic [7:0]  v_minus;
   logic [7:0]  fw_code;
   logic        req_fire;

   vgm_run_mem #(.DEPTH(MAX_RUN), .AW(RUN_AW)) u_mem (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (run_len_ff[RUN_AW-1:0]),
      .wr_data (app_val_ff),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   vgm_fdiv u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  (div_divisor),
      .res      (div_res)
   );

   assign req_chan.ready = (state_ff == ST_IDLE);
   assign csr_chan.ready = 1'b1;
   assign rsp_chan.valid    = rsp_valid_ff;
   assign rsp_chan.out_byte = rsp_byte_ff;
   assign rsp_chan.last     = rsp_last_ff;
   assign req_fire = req_chan.valid && req_chan.ready;

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         phase_ff       <= PH_ACT;
         rsp_valid_ff   <= 1'b0;
         frame_mode_ff  <= 2'd3;
         loop_enable_ff <= 1'b0;
         loop_pos_ff    <= 32'd0;
         c50_ff         <= 17'd0;
         c60_ff         <= 17'd0;
         run_len_ff     <= 8'd0;
         run_first_ff   <= 8'd0;
         run_last_ff    <= 8'd0;
         out_addr_ff    <= 16'd5;
         mark_ff        <= 16'd0;
         loop_addr_ff   <= 16'd0;
         loop_found_ff  <= 1'b0;
         stream_pos_ff  <= 32'd0;
      end else begin
         state_ff       <= state_in;
         phase_ff       <= phase_in;
         rsp_valid_ff   <= rsp_valid_in;
         frame_mode_ff  <= frame_mode_in;
         loop_enable_ff <= loop_enable_in;
         loop_pos_ff    <= loop_pos_in;
         c50_ff         <= c50_in;
         c60_ff         <= c60_in;
         run_len_ff     <= run_len_in;
         run_first_ff   <= run_first_in;
         run_last_ff    <= run_last_in;
         out_addr_ff    <= out_addr_in;
         mark_ff        <= mark_in;
         loop_addr_ff   <= loop_addr_in;
         loop_found_ff  <= loop_found_in;
         stream_pos_ff  <= stream_pos_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      idx_ff       <= idx_in;
      act_cnt_ff   <= act_cnt_in;
      act_b0_ff    <= act_b0_in;
      act_b1_ff    <= act_b1_in;
      act_b2_ff    <= act_b2_in;
      append_ff    <= append_in;
      app_reg_ff   <= app_reg_in;
      app_val_ff   <= app_val_in;
      f50_ff       <= f50_in;
      f60_ff       <= f60_in;
      packs_ff     <= packs_in;
      fin_ff       <= fin_in;
      rsp_byte_ff  <= rsp_byte_in;
      rsp_last_ff  <= rsp_last_in;
   end

   // Request decode: sample counts, stream length and the command's own bytes.
   always_comb begin
      kind = kind_type'(req_chan.kind);
      rp   = req_chan.reg_or_port;
      dv   = req_chan.data_value;
      lo8  = {4'd0, dv[3:0]};
      hi8  = (dv > 8'h0F) ? OP_AY_HI : 8'h00;
      case (kind)
         KIND_WAIT_N:     samp = {1'b0, req_chan.wait_samples};
         KIND_WAIT_735:   samp = WAIT_735;
         KIND_WAIT_882:   samp = WAIT_882;
         KIND_WAIT_SHORT: samp = {13'd0, dv[3:0]} + 17'd1;
         default:         samp = 17'd0;
      endcase
      c50_sum = frame_mode_ff[0] ? (c50_ff + samp) : c50_ff;
      c60_sum = frame_mode_ff[1] ? (c60_ff + samp) : c60_ff;
      d_f50 = (kind != KIND_END) && frame_mode_ff[0] && (c50_sum >= FRAMES_50);
      d_f60 = (kind != KIND_END) && frame_mode_ff[1] && (c60_sum >= FRAMES_60);
      case (kind)
         KIND_AY, KIND_WAIT_N: adv = 2'd3;
         KIND_SCC:             adv = 2'd0;
         default:              adv = 2'd1;
      endcase
      // The SCC write advances by four, which does not fit the narrow step.
      sp_sum = {1'b0, stream_pos_ff} + ((kind == KIND_SCC) ? 33'd4 : {31'd0, adv});
      sp_new = sp_sum[32] ? 32'hFFFF_FFFF : sp_sum[31:0];
      mark_new = (kind == KIND_AY) ? out_addr_ff : mark_ff;
      scc_reg  = scc_base(rp) + req_chan.reg_offset;
      d_flush  = 1'b0;
      d_append = 1'b0;
      d_cnt    = 2'd0;
      d_b0     = 8'd0;
      d_b1     = 8'd0;
      d_b2     = 8'd0;
      case (kind)
         KIND_AY: begin
            if (rp <= AY_R13) begin
               d_flush = 1'b1;
               d_cnt   = 2'd1;
               case (rp)
                  AY_R0, AY_R2, AY_R4, AY_R7, AY_R11, AY_R12: begin
                     d_cnt = 2'd2;
                     d_b0  = rp;
                     d_b1  = dv;
                  end
                  AY_R1:   d_b0 = OP_AY_R1 + lo8;
                  AY_R3:   d_b0 = OP_AY_R3 + lo8;
                  AY_R5:   d_b0 = OP_AY_R5 + lo8;
                  AY_R6:   d_b0 = OP_AY_R6 + hi8 + lo8;
                  AY_R8:   d_b0 = OP_AY_R8 + hi8 + lo8;
                  AY_R9:   d_b0 = OP_AY_R9 + hi8 + lo8;
                  AY_R10:  d_b0 = OP_AY_R10 + hi8 + lo8;
                  default: d_b0 = OP_AY_R13 + lo8;
               endcase
            end
         end
         KIND_SCC: begin
            if (scc_reg >= SCC_REG_LOW && scc_reg <= SCC_REG_FREQ_HI && !scc_reg[0]) begin
               d_flush = 1'b1;
               d_cnt   = 2'd2;
               d_b0    = OP_SCC_FREQ + {4'd0, scc_reg[3:0]};
               d_b1    = dv;
            end else if (scc_reg >= SCC_REG_NIB_LO && scc_reg <= SCC_REG_NIB_HI) begin
               d_flush = 1'b1;
               d_cnt   = 2'd2;
               d_b0    = OP_SCC_NIBBLE;
               d_b1    = {scc_reg[3:0], dv[3:0]};
            end else if (scc_reg == SCC_REG_MODE) begin
               d_flush = 1'b1;
               d_cnt   = 2'd2;
               d_b0    = OP_SCC_NIBBLE;
               d_b1    = {dv[4] ? 4'hF : 4'h0, dv[3:0]};
            end else begin
               // Plain register: extend the run or start a new one.
               d_append = 1'b1;
               d_flush  = (run_len_ff != 8'd0) &&
                          (({1'b0, scc_reg} != ({1'b0, run_last_ff} + 9'd1)) ||
                           (run_len_ff >= RUN_MAX));
            end
         end
         KIND_END: begin
            d_flush = 1'b1;
            if (loop_enable_ff) begin
               d_cnt = 2'd3;
               d_b0  = OP_LOOP;
               d_b1  = loop_addr_ff[7:0];
               d_b2  = loop_addr_ff[15:8];
            end else begin
               d_cnt = 2'd1;
               d_b0  = OP_END;
            end
         end
         default: ;
      endcase
   end

   // Byte to emit: flush header then values, command bytes or frame waits.
   always_comb begin
      fl_hdr   = (run_len_ff == 8'd1) ? 9'd2 : 9'd3;
      fl_total = (run_len_ff == 8'd1) ? 9'd3 : ({1'b0, run_len_ff} + 9'd3);
      fl_k     = idx_ff - fl_hdr;
      can_emit = !rsp_valid_ff || rsp_chan.ready;
      fw_code  = (phase_ff == PH_FW50) ? OP_FW50 : OP_FW60;
      v_minus  = div_res.quot - 8'd1;
      later    = (phase_ff != PH_ACT) || (act_cnt_ff != 2'd0) || f50_ff || f60_ff;
      emit      = 1'b0;
      emit_byte = 8'd0;
      emit_last = 1'b0;
      case (state_ff)
         ST_FLUSH: begin
            emit = can_emit;
            if (run_len_ff == 8'd1) begin
               case (idx_ff[1:0])
                  2'd0:    emit_byte = OP_SINGLE;
                  2'd1:    emit_byte = run_first_ff;
                  default: emit_byte = rd_data;
               endcase
            end else if (idx_ff == 9'd0) begin
               emit_byte = OP_BLOCK;
            end else if (idx_ff == 9'd1) begin
               emit_byte = run_first_ff;
            end else if (idx_ff == 9'd2) begin
               emit_byte = run_len_ff;
            end else begin
               emit_byte = rd_data;
            end
            emit_last = (idx_ff == fl_total - 9'd1) && !later;
         end
         ST_ACT: begin
            emit = can_emit && (act_cnt_ff != 2'd0);
            case (idx_ff[1:0])
               2'd0:    emit_byte = act_b0_ff;
               2'd1:    emit_byte = act_b1_ff;
               default: emit_byte = act_b2_ff;
            endcase
            emit_last = (idx_ff[1:0] == act_cnt_ff - 2'd1) && !f50_ff && !f60_ff;
         end
         ST_FW: begin
            emit      = can_emit;
            emit_byte = (idx_ff[3:0] < packs_ff) ? (fw_code | OP_PACK_MASK) : fin_ff;
            emit_last = (idx_ff[3:0] == packs_ff) && !((phase_ff == PH_FW50) && f60_ff);
         end
         default: ;
      endcase
      // Read the value to show now, or the next one when this one leaves.
      if (state_ff != ST_FLUSH || idx_ff < fl_hdr) begin
         rd_addr = '0;
      end else begin
         rd_addr = emit ? RUN_AW'(fl_k + 9'd1) : RUN_AW'(fl_k);
      end
   end

   // Next state and state updates.
   always_comb begin
      state_in       = state_ff;
      phase_in       = phase_ff;
      idx_in         = idx_ff;
      act_cnt_in     = act_cnt_ff;
      act_b0_in      = act_b0_ff;
      act_b1_in      = act_b1_ff;
      act_b2_in      = act_b2_ff;
      append_in      = append_ff;
      app_reg_in     = app_reg_ff;
      app_val_in     = app_val_ff;
      f50_in         = f50_ff;
      f60_in         = f60_ff;
      packs_in       = packs_ff;
      fin_in         = fin_ff;
      frame_mode_in  = frame_mode_ff;
      loop_enable_in = loop_enable_ff;
      loop_pos_in    = loop_pos_ff;
      c50_in         = c50_ff;
      c60_in         = c60_ff;
      run_len_in     = run_len_ff;
      run_first_in   = run_first_ff;
      run_last_in    = run_last_ff;
      out_addr_in    = out_addr_ff;
      mark_in        = mark_ff;
      loop_addr_in   = loop_addr_ff;
      loop_found_in  = loop_found_ff;
      stream_pos_in  = stream_pos_ff;
      wr_en          = 1'b0;
      div_start      = 1'b0;
      div_dividend   = (phase_ff == PH_FW50) ? c50_ff : c60_ff;
      div_divisor    = (phase_ff == PH_FW50) ? FRAMES_50 : FRAMES_60;

      // Response register.
      rsp_valid_in = rsp_valid_ff && !rsp_chan.ready;
      rsp_byte_in  = rsp_byte_ff;
      rsp_last_in  = rsp_last_ff;
      if (emit) begin
         rsp_valid_in = 1'b1;
         rsp_byte_in  = emit_byte;
         rsp_last_in  = emit_last;
         out_addr_in  = out_addr_ff + 16'd1;
      end

      // Configuration writes.
      if (csr_chan.valid) begin
         case (csr_chan.index)
            CSR_FRAME_MODE:    frame_mode_in  = csr_chan.data[1:0];
            CSR_LOOP_ENABLE:   loop_enable_in = csr_chan.data[0];
            CSR_LOOP_POSITION: loop_pos_in    = csr_chan.data;
            CSR_OUTPUT_BASE:   out_addr_in    = csr_chan.data[15:0];
            default: ;
         endcase
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               act_cnt_in   = d_cnt;
               act_b0_in    = d_b0;
               act_b1_in    = d_b1;
               act_b2_in    = d_b2;
               append_in    = d_append;
               app_reg_in   = scc_reg;
               app_val_in   = dv;
               f50_in       = d_f50;
               f60_in       = d_f60;
               idx_in       = 9'd0;
               phase_in     = PH_ACT;
               if (kind != KIND_END) begin
                  c50_in        = c50_sum;
                  c60_in        = c60_sum;
                  stream_pos_in = sp_new;
                  mark_in       = mark_new;
                  if (loop_enable_ff && !loop_found_ff && sp_new >= loop_pos_ff) begin
                     loop_addr_in  = mark_new;
                     loop_found_in = 1'b1;
                  end
               end
               state_in = (d_flush && run_len_ff != 8'd0) ? ST_FLUSH : ST_ACT;
            end
         end
         ST_FLUSH: begin
            if (emit) begin
               idx_in = idx_ff + 9'd1;
               if (idx_ff == fl_total - 9'd1) begin
                  run_len_in = 8'd0;
                  idx_in     = 9'd0;
                  state_in   = (phase_ff == PH_ACT) ? ST_ACT : ST_DIV_START;
               end
            end
         end
         ST_ACT: begin
            if (act_cnt_ff == 2'd0) begin
               if (append_ff) begin
                  wr_en       = 1'b1;
                  run_len_in  = run_len_ff + 8'd1;
                  run_last_in = app_reg_ff;
                  if (run_len_ff == 8'd0) begin
                     run_first_in = app_reg_ff;
                  end
               end
               idx_in = 9'd0;
               if (f50_ff) begin
                  phase_in = PH_FW50;
                  state_in = (append_ff || run_len_ff != 8'd0) ? ST_FLUSH : ST_DIV_START;
               end else if (f60_ff) begin
                  phase_in = PH_FW60;
                  state_in = (append_ff || run_len_ff != 8'd0) ? ST_FLUSH : ST_DIV_START;
               end else begin
                  state_in = ST_IDLE;
               end
            end else if (emit) begin
               idx_in = idx_ff + 9'd1;
               if (idx_ff[1:0] == act_cnt_ff - 2'd1) begin
                  idx_in = 9'd0;
                  if (f50_ff) begin
                     phase_in = PH_FW50;
                     state_in = (run_len_ff != 8'd0) ? ST_FLUSH : ST_DIV_START;
                  end else if (f60_ff) begin
                     phase_in = PH_FW60;
                     state_in = (run_len_ff != 8'd0) ? ST_FLUSH : ST_DIV_START;
                  end else begin
                     state_in = ST_IDLE;
                  end
               end
            end
         end
         ST_DIV_START: begin
            // The frame wait's mark lies after any flush.
            mark_in   = out_addr_ff;
            div_start = 1'b1;
            state_in  = ST_DIV;
         end
         ST_DIV: begin
            if (div_res.done) begin
               packs_in = v_minus[7:4];
               fin_in   = fw_code + {4'd0, v_minus[3:0]};
               idx_in   = 9'd0;
               if (phase_ff == PH_FW50) begin
                  c50_in = div_res.rem;
               end else begin
                  c60_in = div_res.rem;
               end
               state_in = ST_FW;
            end
         end
         ST_FW: begin
            if (emit) begin
               idx_in = idx_ff + 9'd1;
               if (idx_ff[3:0] == packs_ff) begin
                  idx_in = 9'd0;
                  if (phase_ff == PH_FW50 && f60_ff) begin
                     phase_in = PH_FW60;
                     state_in = (run_len_ff != 8'd0) ? ST_FLUSH : ST_DIV_START;
                  end else begin
                     state_in = ST_IDLE;
                  end
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end
endmodule
`default_nettype wire

### sv/vgm_run_mem.sv
`default_nettype none
// Storage for the values of the pending SCC run, registered read.
module vgm_run_mem #(
   parameter int DEPTH = 32,
   parameter int AW    = 5
) (
   input  wire logic          clock,
   input  wire logic          wr_en,
   input  wire logic [AW-1:0] wr_addr,
   input  wire logic [7:0]    wr_data,
   input  wire logic [AW-1:0] rd_addr,
   output logic      [7:0]    rd_data
);
   logic [7:0] mem_ff [DEPTH];
   logic [7:0] rd_data_ff;

   // Single write port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Registered read port.
   always_ff @(posedge clock) begin
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;
endmodule
`default_nettype wire

### sv/vgm_fdiv.sv
`default_nettype none
// Frame count from a sample counter by reciprocal multiplication. The divisor
// is one of the two frame periods; the reciprocals are exact for any 17-bit
// dividend.
module vgm_fdiv (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              start,
   input  wire logic [16:0]       dividend,
   input  wire logic [16:0]       divisor,
   output vgm_pkg::div_res_type   res
);
   import vgm_pkg::*;

   // Scaled reciprocals of the frame periods, taken with a shift of 27.
   localparam logic [17:0] RECIP_50 = 18'd152175;
   localparam logic [17:0] RECIP_60 = 18'd182610;

   logic        mul_ff, mul_in;
   logic        done_ff, done_in;
   logic [34:0] prod_ff, prod_in;
   logic [16:0] dvd_ff, dvd_in;
   logic [16:0] dvs_ff, dvs_in;
   logic [7:0]  quot_ff, quot_in;
   logic [16:0] rem_ff, rem_in;
   logic [17:0] recip;
   logic [7:0]  quot;
   logic [16:0] back;

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         mul_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         mul_ff  <= mul_in;
         done_ff <= done_in;
      end
   end

   // Datapath registers.
   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
      dvd_ff  <= dvd_in;
      dvs_ff  <= dvs_in;
      quot_ff <= quot_in;
      rem_ff  <= rem_in;
   end

   // Multiply on start; the registered product gives quotient and remainder.
   always_comb begin
      recip   = (divisor == FRAMES_50) ? RECIP_50 : RECIP_60;
      quot    = prod_ff[34:27];
      back    = {9'd0, quot} * dvs_ff;
      mul_in  = start;
      done_in = mul_ff;
      prod_in = prod_ff;
      dvd_in  = dvd_ff;
      dvs_in  = dvs_ff;
      quot_in = quot_ff;
      rem_in  = rem_ff;
      if (start) begin
         prod_in = {18'd0, dividend} * {17'd0, recip};
         dvd_in  = dividend;
         dvs_in  = divisor;
      end
      if (mul_ff) begin
         quot_in = quot;
         rem_in  = dvd_ff - back;
      end
   end

   assign res.done = done_ff;
   assign res.quot = quot_ff;
   assign res.rem  = rem_ff;
endmodule
`default_nettype wire

### sv/vgm_checker.sv
`default_nettype none
// Port-level checks on the bytecode emitter.
module vgm_checker (
   input wire logic       clock,
   input wire logic       reset,
   input wire logic       req_valid,
   input wire logic       req_ready,
   input wire logic       rsp_valid,
   input wire logic       rsp_ready,
   input wire logic [7:0] rsp_byte,
   input wire logic       rsp_last
);
   `include "vgm_to_compact_music_bytecode_top_assert.svh"

   // A stalled response keeps its byte.
   `VGM_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_byte), "response dropped or changed while stalled")

   // While a byte that is not the last one waits, no new request is taken.
   `VGM_ASSERT_SAME(a_busy, clock, reset, rsp_valid && !rsp_last, !req_ready, "request taken before the previous command finished")

   // An accepted request leaves the block busy in the next cycle.
   `VGM_ASSERT_NEXT(a_accept_busy, clock, reset, req_valid && req_ready, !req_ready, "ready stayed high after a request")

   // Reset leaves no response pending.
   `VGM_ASSERT_ALWAYS_NEXT(a_reset_empty, clock, reset, !rsp_valid, "response pending after reset")
endmodule

bind vgm_to_compact_music_bytecode_top vgm_checker u_vgm_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_chan.valid),
   .req_ready (req_chan.ready),
   .rsp_valid (rsp_chan.valid),
   .rsp_ready (rsp_chan.ready),
   .rsp_byte  (rsp_chan.out_byte),
   .rsp_last  (rsp_chan.last)
);
`default_nettype wire
